>>> design/idq_pkg.sv
// ----------------------------------------------------------------------------
// idq_pkg
// Shared constants, codes, a helper function and controller/datapath bundles
// for the indexed deque unit.
// ----------------------------------------------------------------------------
package idq_pkg;

  localparam int DEPTH = 256;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int PosW  = 10;
  localparam int IW    = (CW > PosW) ? CW : PosW;
  localparam int DataW = 32;
  localparam int LenW  = 9;
  localparam int CmdW  = 3;
  localparam int StW   = 2;

  localparam logic [CmdW-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CmdW-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CmdW-1:0] CMD_POP_BACK   = 3'd2;
  localparam logic [CmdW-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CmdW-1:0] CMD_READ       = 3'd4;
  localparam logic [CmdW-1:0] CMD_REMOVE     = 3'd5;
  localparam logic [CmdW-1:0] CMD_CLEAR      = 3'd6;

  localparam logic [StW-1:0] ST_OK    = 2'd0;
  localparam logic [StW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StW-1:0] ST_RANGE = 2'd2;
  localparam logic [StW-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic load;
    logic exec;
    logic rd_emit;
    logic shift_step;
    logic drain;
  } idq_ctrl_t;

  typedef struct packed {
    logic need_read;
    logic need_shift;
    logic shift_last;
  } idq_stat_t;

  // physical slot of a logical position; position stays below DEPTH
  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] front, logic [IW-1:0] pos);
    logic [IW:0] s;
    s = (IW+1)'(front) + (IW+1)'(pos);
    if (s >= (IW+1)'(DEPTH)) begin
      s = s - (IW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

endpackage

>>> design/idq_ram.sv
// ----------------------------------------------------------------------------
// idq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module idq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/idq_ctrl.sv
// ----------------------------------------------------------------------------
// idq_ctrl
// Command sequencer: accept, execute, read wait, shift loop and drain.
// ----------------------------------------------------------------------------
module idq_ctrl
  import idq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  idq_stat_t stat,
  output idq_ctrl_t ctrl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (stat.need_read) begin
          state_nxt = S_RDWAIT;
        end else if (stat.need_shift) begin
          state_nxt = S_SHIFT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RDWAIT: state_nxt = S_IDLE;
      S_SHIFT: begin
        if (stat.shift_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign ctrl.load       = (state_r == S_IDLE) && start;
  assign ctrl.exec       = (state_r == S_EXEC);
  assign ctrl.rd_emit    = (state_r == S_RDWAIT);
  assign ctrl.shift_step = (state_r == S_SHIFT);
  assign ctrl.drain      = (state_r == S_DRAIN);

endmodule

>>> design/idq_datapath.sv
// ----------------------------------------------------------------------------
// idq_datapath
// Front pointer, entry count, command registers, entry store and result beat.
// ----------------------------------------------------------------------------
module idq_datapath
  import idq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  idq_ctrl_t               ctrl,
  output idq_stat_t               stat,
  input  logic [CmdW-1:0]         in_command,
  input  logic signed [DataW-1:0] in_item_value,
  input  logic [PosW-1:0]         in_position,
  output logic                    out_valid,
  output logic signed [DataW-1:0] out_read_value,
  output logic [StW-1:0]          out_status,
  output logic [LenW-1:0]         out_length
);

  logic [CmdW-1:0]  cmd_r,   cmd_nxt;
  logic [DataW-1:0] val_r,   val_nxt;
  logic [PosW-1:0]  pos_r,   pos_nxt;
  logic [AW-1:0]    front_r, front_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r,   idx_nxt;
  logic [AW-1:0]    tgt_r,   tgt_nxt;
  logic             pend_r,  pend_nxt;

  logic             ov_r,  ov_nxt;
  logic [DataW-1:0] orv_r, orv_nxt;
  logic [StW-1:0]   ost_r, ost_nxt;
  logic [LenW-1:0]  olen_r, olen_nxt;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [DataW-1:0] mem_rdata;

  logic             full;
  logic             empty;
  logic             out_of_range;
  logic [StW-1:0]   st;
  logic [IW-1:0]    pos_w;
  logic [IW-1:0]    idx_w;

  assign pos_w        = IW'(pos_r);
  assign idx_w        = IW'(idx_r);
  assign full         = (count_r == CW'(DEPTH));
  assign empty        = (count_r == '0);
  assign out_of_range = (pos_w >= IW'(count_r));

  always_comb begin
    unique case (cmd_r)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: st = full ? ST_FULL : ST_OK;
      CMD_POP_BACK, CMD_POP_FRONT:   st = empty ? ST_EMPTY : ST_OK;
      CMD_READ, CMD_REMOVE: begin
        priority if (empty) begin
          st = ST_EMPTY;
        end else if (out_of_range) begin
          st = ST_RANGE;
        end else begin
          st = ST_OK;
        end
      end
      default: st = ST_OK;
    endcase
  end

  assign stat.need_read  = (cmd_r == CMD_READ) && (st == ST_OK);
  assign stat.need_shift = (cmd_r == CMD_REMOVE) && (st == ST_OK) &&
                           ((IW+1)'(pos_r) + (IW+1)'(1) < (IW+1)'(count_r));
  assign stat.shift_last = ((CW+1)'(idx_r) + (CW+1)'(2) == (CW+1)'(count_r));

  always_comb begin
    cmd_nxt   = cmd_r;
    val_nxt   = val_r;
    pos_nxt   = pos_r;
    front_nxt = front_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    tgt_nxt   = tgt_r;
    pend_nxt  = 1'b0;
    ov_nxt    = 1'b0;
    orv_nxt   = '0;
    ost_nxt   = ST_OK;
    mem_we    = 1'b0;
    mem_waddr = tgt_r;
    mem_wdata = mem_rdata;
    mem_raddr = slot_of(front_r, idx_w + IW'(1));

    if (ctrl.load) begin
      cmd_nxt = in_command;
      val_nxt = in_item_value;
      pos_nxt = in_position;
    end

    if (ctrl.exec) begin
      priority if (stat.need_read) begin
        mem_raddr = slot_of(front_r, pos_w);
      end else if (stat.need_shift) begin
        idx_nxt = CW'(pos_r);
      end else begin
        ov_nxt  = 1'b1;
        ost_nxt = st;
        if (st == ST_OK) begin
          unique case (cmd_r)
            CMD_PUSH_BACK: begin
              mem_we    = 1'b1;
              mem_waddr = slot_of(front_r, IW'(count_r));
              mem_wdata = val_r;
              count_nxt = count_r + CW'(1);
            end
            CMD_PUSH_FRONT: begin
              front_nxt = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
              mem_we    = 1'b1;
              mem_waddr = front_nxt;
              mem_wdata = val_r;
              count_nxt = count_r + CW'(1);
            end
            CMD_POP_BACK: count_nxt = count_r - CW'(1);
            CMD_POP_FRONT: begin
              front_nxt = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + AW'(1);
              count_nxt = count_r - CW'(1);
            end
            CMD_REMOVE: count_nxt = count_r - CW'(1);
            CMD_CLEAR: begin
              front_nxt = '0;
              count_nxt = '0;
            end
            default: ;
          endcase
        end
      end
    end

    if (ctrl.rd_emit) begin
      ov_nxt  = 1'b1;
      orv_nxt = mem_rdata;
    end

    // read the next entry, write back the one fetched last cycle
    if (ctrl.shift_step) begin
      tgt_nxt  = slot_of(front_r, idx_w);
      idx_nxt  = idx_r + CW'(1);
      pend_nxt = 1'b1;
      mem_we   = pend_r;
    end

    if (ctrl.drain) begin
      mem_we    = pend_r;
      count_nxt = count_r - CW'(1);
      ov_nxt    = 1'b1;
    end

    olen_nxt = LenW'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    val_r  <= val_nxt;
    pos_r  <= pos_nxt;
    idx_r  <= idx_nxt;
    tgt_r  <= tgt_nxt;
    orv_r  <= orv_nxt;
    ost_r  <= ost_nxt;
    olen_r <= olen_nxt;
  end

  idq_ram #(
    .WIDTH (DataW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_valid      = ov_r;
  assign out_read_value = orv_r;
  assign out_status     = ost_r;
  assign out_length     = olen_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_r && ctrl.exec))
    else $error("shift write-back overlaps command execution");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |=> !ov_r)
    else $error("result beats back to back");

  a_drain_pending: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.drain |-> pend_r)
    else $error("drain without a fetched entry");
`endif

endmodule

>>> design/indexed_deque_unit.sv
// ----------------------------------------------------------------------------
// indexed_deque_unit
// Bounded double-ended queue of signed 32-bit values with access by position.
//
// Command channel: drive in_command, in_item_value and in_position with start
// high; the command is taken at a clock edge where busy is low. Each command
// gives exactly one result beat: out_valid is high for one cycle with
// out_read_value, out_status and out_length. The receiver cannot stall; the
// beat must be captured in that cycle.
// Sequencing: push, pop, clear and failing commands execute and then return
// the beat, and the next command can be taken in the cycle that shows it. A
// successful read adds a wait for the store's registered read port. A remove
// with k entries behind the removed position copies those entries one per
// cycle through the single read and write port of the store, then drains the
// last write-back before the beat; with k zero it returns like a pop.
// Reset (rst_n low, synchronous) empties the queue and returns the front
// pointer to slot 0; store contents are not cleared.
// ----------------------------------------------------------------------------
module indexed_deque_unit
  import idq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [CmdW-1:0]         in_command,
  input  logic signed [DataW-1:0] in_item_value,
  input  logic [PosW-1:0]         in_position,
  output logic                    out_valid,
  output logic signed [DataW-1:0] out_read_value,
  output logic [StW-1:0]          out_status,
  output logic [LenW-1:0]         out_length
);

  idq_ctrl_t ctrl;
  idq_stat_t stat;

  idq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  idq_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .stat           (stat),
    .in_command     (in_command),
    .in_item_value  (in_item_value),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_length     (out_length)
  );

endmodule

>>> verif/idq_checker.sv
// ----------------------------------------------------------------------------
// idq_checker
// Watches the command and result channels of the indexed deque unit, keeps
// its own copy of the deque contents, predicts the result beat of every
// accepted command and compares it field by field with the beats the block
// returns, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module idq_checker
  import idq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic [CmdW-1:0]         in_command,
  input  logic signed [DataW-1:0] in_item_value,
  input  logic [PosW-1:0]         in_position,
  input  logic                    out_valid,
  input  logic signed [DataW-1:0] out_read_value,
  input  logic [StW-1:0]          out_status,
  input  logic [LenW-1:0]         out_length,
  output int                      mismatch_count,
  output int                      outstanding,
  output int                      beats_checked,
  output int                      peak_length,
  output int                      dropped_pushes
);

  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    logic [StW-1:0]          status;
    logic [LenW-1:0]         length;
  } deque_beat_t;

  deque_beat_t             expected_beats[$];
  logic signed [DataW-1:0] slots[DEPTH];
  int                      head;
  int                      fill;
  int                      errs;
  int                      checked;
  int                      peak;
  int                      dropped;

  function automatic deque_beat_t deque_step(logic [CmdW-1:0] cmd,
                                             logic signed [DataW-1:0] val,
                                             logic [PosW-1:0] pos);
    deque_beat_t beat;
    int          p;
    p = pos;
    beat.read_value = '0;
    beat.status     = ST_OK;
    case (cmd)
      CMD_PUSH_BACK: begin
        if (fill >= DEPTH) begin
          beat.status = ST_FULL;
        end else begin
          slots[(head + fill) % DEPTH] = val;
          fill++;
        end
      end
      CMD_PUSH_FRONT: begin
        if (fill >= DEPTH) begin
          beat.status = ST_FULL;
        end else begin
          head = (head + DEPTH - 1) % DEPTH;
          slots[head] = val;
          fill++;
        end
      end
      CMD_POP_BACK: begin
        if (fill == 0) beat.status = ST_EMPTY;
        else fill--;
      end
      CMD_POP_FRONT: begin
        if (fill == 0) begin
          beat.status = ST_EMPTY;
        end else begin
          head = (head + 1) % DEPTH;
          fill--;
        end
      end
      CMD_READ: begin
        if (fill == 0) beat.status = ST_EMPTY;
        else if (p >= fill) beat.status = ST_RANGE;
        else beat.read_value = slots[(head + p) % DEPTH];
      end
      CMD_REMOVE: begin
        if (fill == 0) begin
          beat.status = ST_EMPTY;
        end else if (p >= fill) begin
          beat.status = ST_RANGE;
        end else begin
          // close the gap behind the removed entry
          for (int i = p; i + 1 < fill; i++) begin
            slots[(head + i) % DEPTH] = slots[(head + i + 1) % DEPTH];
          end
          fill--;
        end
      end
      CMD_CLEAR: begin
        fill = 0;
        head = 0;
      end
      default: begin
      end
    endcase
    beat.length = LenW'(fill);
    return beat;
  endfunction

  always @(posedge clk) begin
    deque_beat_t want;
    if (!rst_n) begin
      expected_beats.delete();
      head = 0;
      fill = 0;
    end else begin
      if (out_valid) begin
        if (expected_beats.size() == 0) begin
          errs++;
          $error("result beat with no command waiting: read_value %0d status %0d length %0d",
                 out_read_value, out_status, out_length);
        end else begin
          want = expected_beats.pop_front();
          checked++;
          if (out_read_value !== want.read_value) begin
            errs++;
            if (errs <= 200)
              $error("read_value: expected %0d, actual %0d", want.read_value, out_read_value);
          end
          if (out_status !== want.status) begin
            errs++;
            if (errs <= 200)
              $error("status: expected %0d, actual %0d", want.status, out_status);
          end
          if (out_length !== want.length) begin
            errs++;
            if (errs <= 200)
              $error("length: expected %0d, actual %0d", want.length, out_length);
          end
        end
      end
      if (start && !busy) begin
        want = deque_step(in_command, in_item_value, in_position);
        if (want.status == ST_FULL) dropped++;
        if (fill > peak) peak = fill;
        expected_beats.push_back(want);
      end
    end
    mismatch_count <= errs;
    outstanding    <= expected_beats.size();
    beats_checked  <= checked;
    peak_length    <= peak;
    dropped_pushes <= dropped;
  end

  final begin
  end

endmodule

>>> verif/indexed_deque_unit_tb.sv
// ----------------------------------------------------------------------------
// indexed_deque_unit_tb
// Drives the indexed deque unit with a short directed command list covering
// empty, out-of-range and wrap-around cases, then with random traffic
// that alternates between filling to capacity, draining and mixed use, under
// three levels of sender idling. A checker beside the block predicts and
// compares every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_deque_unit_tb;
  import idq_pkg::*;

  localparam logic [CmdW-1:0] CMD_NOP = 3'd7;
  localparam int PHASE_BEATS = 500;

  typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic [CmdW-1:0]         in_command = '0;
  logic signed [DataW-1:0] in_item_value = '0;
  logic [PosW-1:0]         in_position = '0;
  logic                    busy;
  logic                    out_valid;
  logic signed [DataW-1:0] out_read_value;
  logic [StW-1:0]          out_status;
  logic [LenW-1:0]         out_length;

  int            fail_count;
  int            pending_beats;
  int            beats_checked;
  int            peak_length;
  int            dropped_pushes;
  int            idle_pct = 26;
  int            cur_len = 0;
  int            commands_sent = 0;
  traffic_mode_t mode;

  indexed_deque_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_item_value (in_item_value),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_read_value(out_read_value),
    .out_status    (out_status),
    .out_length    (out_length)
  );

  idq_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_item_value (in_item_value),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_read_value(out_read_value),
    .out_status    (out_status),
    .out_length    (out_length),
    .mismatch_count(fail_count),
    .outstanding   (pending_beats),
    .beats_checked (beats_checked),
    .peak_length   (peak_length),
    .dropped_pushes(dropped_pushes)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (out_valid) cur_len <= out_length;
  end

  task automatic send_cmd(input logic [CmdW-1:0] cmd, input logic signed [DataW-1:0] val,
                          input logic [PosW-1:0] pos);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_command    <= cmd;
    in_item_value <= val;
    in_position   <= pos;
    do @(posedge clk); while (busy);
    commands_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_beats != 0);
  endtask

  function automatic logic [CmdW-1:0] pick_command(traffic_mode_t m);
    int r;
    r = $urandom_range(0, 99);
    case (m)
      MODE_FILL: begin
        if (r < 44) return CMD_PUSH_BACK;
        if (r < 88) return CMD_PUSH_FRONT;
        if (r < 94) return CMD_READ;
        if (r < 96) return CMD_REMOVE;
        if (r < 98) return CMD_POP_BACK;
        if (r < 99) return CMD_POP_FRONT;
        return CMD_NOP;
      end
      MODE_DRAIN: begin
        if (r < 8) return CMD_PUSH_BACK;
        if (r < 15) return CMD_PUSH_FRONT;
        if (r < 33) return CMD_POP_BACK;
        if (r < 51) return CMD_POP_FRONT;
        if (r < 75) return CMD_REMOVE;
        if (r < 96) return CMD_READ;
        if (r < 98) return CMD_NOP;
        return CMD_CLEAR;
      end
      default: begin
        if (r < 20) return CMD_PUSH_BACK;
        if (r < 38) return CMD_PUSH_FRONT;
        if (r < 48) return CMD_POP_BACK;
        if (r < 58) return CMD_POP_FRONT;
        if (r < 80) return CMD_READ;
        if (r < 93) return CMD_REMOVE;
        if (r < 97) return CMD_NOP;
        return CMD_CLEAR;
      end
    endcase
  endfunction

  function automatic logic [PosW-1:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75 && cur_len > 0) return PosW'($urandom_range(0, cur_len - 1));
    if (r < 85) return PosW'(cur_len);
    if (r < 90) return '0;
    return PosW'($urandom_range(0, 1023));
  endfunction

  function automatic logic signed [DataW-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 32'sh7FFF_FFFF;
    if (r < 10) return 32'sh8000_0000;
    if (r < 13) return '0;
    if (r < 16) return -32'sd1;
    return $urandom;
  endfunction

  initial begin
    int hold;
    int seg_left;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_cmd(CMD_READ, 32'sd5, 10'd0);
    send_cmd(CMD_REMOVE, 32'sd5, 10'd0);
    send_cmd(CMD_POP_BACK, '0, '0);
    send_cmd(CMD_POP_FRONT, '0, '0);
    send_cmd(CMD_NOP, -32'sd1, 10'h3FF);
    send_cmd(CMD_PUSH_FRONT, 32'sh8000_0000, 10'h3FF);
    send_cmd(CMD_PUSH_BACK, 32'sh7FFF_FFFF, '0);
    send_cmd(CMD_PUSH_BACK, '0, '0);
    send_cmd(CMD_PUSH_FRONT, -32'sd1, '0);
    send_cmd(CMD_READ, '0, 10'd0);
    send_cmd(CMD_READ, '0, 10'd3);
    send_cmd(CMD_READ, '0, 10'd4);
    send_cmd(CMD_READ, '0, 10'h3FF);
    send_cmd(CMD_REMOVE, '0, 10'd1);
    send_cmd(CMD_REMOVE, '0, 10'h3FF);
    send_cmd(CMD_REMOVE, '0, 10'd1);
    send_cmd(CMD_READ, '0, 10'd1);
    send_cmd(CMD_POP_BACK, '0, '0);
    send_cmd(CMD_NOP, '0, '0);
    send_cmd(CMD_CLEAR, '0, '0);
    send_cmd(CMD_READ, '0, 10'd0);
    send_cmd(CMD_PUSH_BACK, 32'sh5555_5555, '0);
    send_cmd(CMD_REMOVE, '0, 10'd0);
    send_cmd(CMD_POP_FRONT, '0, '0);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 26 : (ph == 1) ? 50 : 0;
      mode = MODE_FILL;
      hold = 0;
      seg_left = 150;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        send_cmd(pick_command(mode), pick_value(), pick_position());
        // leave fill only after dwelling at capacity; leave drain after dwelling empty or when the segment runs out
        if (mode == MODE_FILL) begin
          if (cur_len == DEPTH) hold++;
          if (hold >= 10) begin
            mode = ($urandom_range(0, 1) != 0) ? MODE_DRAIN : MODE_MIX;
            hold = 0;
            seg_left = $urandom_range(60, 200);
          end
        end else begin
          if (mode == MODE_DRAIN && cur_len == 0) hold++;
          seg_left--;
          if (hold >= 5 || seg_left <= 0) begin
            mode = traffic_mode_t'($urandom_range(0, 2));
            hold = 0;
            seg_left = $urandom_range(60, 200);
          end
        end
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("Sent %0d commands under three idling levels; %0d result beats checked.",
             commands_sent, beats_checked);
    $display("Peak length %0d of %0d, %0d pushes dropped while full.",
             peak_length, DEPTH, dropped_pushes);
    if (fail_count == 0 && pending_beats == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
design/idq_pkg.sv
design/idq_ram.sv
design/idq_ctrl.sv
design/idq_datapath.sv
design/indexed_deque_unit.sv
verif/idq_checker.sv
verif/indexed_deque_unit_tb.sv
